### src/line_rasterizer_macros.svh
// assertion macros for the line rasterizer
`ifndef LINE_RASTERIZER_MACROS_SVH
`define LINE_RASTERIZER_MACROS_SVH

`ifndef ASSERT_OFF
`define LR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define LR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LR_ASSERT(label, prop, msg)
`define LR_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### src/lr_pkg.sv
// types and constants of the line rasterizer
package lr_pkg;

  localparam int CoordBits = 13;
  localparam int GainBits  = CoordBits + 2;
  localparam int ErrBits   = CoordBits + 3;
  localparam int DimBits   = 12;
  localparam int AddrBits  = 2 * DimBits;
  localparam int ColorBits = 32;
  localparam int CfgIdxBits = 2;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [CoordBits-1:0]        span_t;
  typedef logic [GainBits-1:0]         gain_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [DimBits-1:0]          dim_t;
  typedef logic [AddrBits-1:0]         addr_t;
  typedef logic [ColorBits-1:0]        color_t;
  typedef logic [CfgIdxBits-1:0]       cfg_idx_t;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdStep = 1'b1;

  localparam cfg_idx_t CfgFrameWidth  = cfg_idx_t'(0);
  localparam cfg_idx_t CfgFrameHeight = cfg_idx_t'(1);

  localparam dim_t FrameDimReset = dim_t'(800);

endpackage

### src/line_rasterizer.sv
// line rasterizer: bresenham line drawing, one pixel per step item
// flow: a step item is accepted into the input register and moves on to the result
//   register once the result side is free; load items give no result
// throughput: one item per cycle, held back only by a stall on the result side
// reset: no line active, frame size 800 by 800, both pipeline registers empty
`include "line_rasterizer_macros.svh"

module line_rasterizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  lr_pkg::cfg_idx_t  cfg_index_i,
  input  lr_pkg::dim_t      cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              command_i,
  input  lr_pkg::coord_t    x_start_i,
  input  lr_pkg::coord_t    y_start_i,
  input  lr_pkg::coord_t    x_end_i,
  input  lr_pkg::coord_t    y_end_i,
  input  lr_pkg::color_t    pixel_color_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              pixel_valid_o,
  output logic              write_enable_o,
  output lr_pkg::coord_t    pixel_x_o,
  output lr_pkg::coord_t    pixel_y_o,
  output lr_pkg::addr_t     address_o,
  output lr_pkg::color_t    out_color_o,
  output logic              last_o
);
  import lr_pkg::*;

  // configuration
  dim_t frame_width_q, frame_height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FrameDimReset;
      frame_height_q <= FrameDimReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CfgFrameWidth) begin
        frame_width_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgFrameHeight) begin
        frame_height_q <= cfg_data_i;
      end
    end
  end

  // input register
  logic   s1_valid_q, s1_valid_d;
  logic   s1_cmd_q;
  coord_t s1_x0_q, s1_y0_q, s1_x1_q, s1_y1_q;
  color_t s1_color_q;
  logic   in_fire, s1_move, s1_step, out_free;

  assign out_free   = !out_valid_o || !out_stall_i;
  assign s1_move    = s1_valid_q && ((s1_cmd_q == CmdLoad) || out_free);
  assign s1_step    = s1_move && (s1_cmd_q == CmdStep);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_fire    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_move) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q   <= command_i;
      s1_x0_q    <= x_start_i;
      s1_y0_q    <= y_start_i;
      s1_x1_q    <= x_end_i;
      s1_y1_q    <= y_end_i;
      s1_color_q <= pixel_color_i;
    end
  end

  // line state
  logic   busy_q, busy_d;
  logic   steep_q, steep_d;
  coord_t major_pos_q, major_pos_d;
  coord_t major_stop_q, major_stop_d;
  coord_t minor_pos_q, minor_pos_d;
  logic   minor_dir_q, minor_dir_d;
  err_t   error_term_q, error_term_d;
  gain_t  error_gain_q, error_gain_d;
  gain_t  error_drop_q, error_drop_d;
  color_t line_color_q, line_color_d;

  // load setup
  logic signed [CoordBits:0] dx, dy, ndx, ndy;
  span_t  adx, ady, maj_span, min_span;
  logic   ld_steep;
  coord_t maj0, maj1, min0, min1;

  always_comb begin
    dx  = {s1_x1_q[CoordBits-1], s1_x1_q} - {s1_x0_q[CoordBits-1], s1_x0_q};
    dy  = {s1_y1_q[CoordBits-1], s1_y1_q} - {s1_y0_q[CoordBits-1], s1_y0_q};
    ndx = -dx;
    ndy = -dy;
    adx = dx[CoordBits] ? ndx[CoordBits-1:0] : dx[CoordBits-1:0];
    ady = dy[CoordBits] ? ndy[CoordBits-1:0] : dy[CoordBits-1:0];
    ld_steep = ady > adx;
    if (ld_steep) begin
      maj0 = s1_y0_q; maj1 = s1_y1_q; min0 = s1_x0_q; min1 = s1_x1_q;
      maj_span = ady; min_span = adx;
    end else begin
      maj0 = s1_x0_q; maj1 = s1_x1_q; min0 = s1_y0_q; min1 = s1_y1_q;
      maj_span = adx; min_span = ady;
    end
  end

  // current pixel
  coord_t px, py;
  logic   in_frame, fin;
  err_t   err_sum;
  addr_t  addr_calc;

  always_comb begin
    px = steep_q ? minor_pos_q : major_pos_q;
    py = steep_q ? major_pos_q : minor_pos_q;
    in_frame = !px[CoordBits-1] && !py[CoordBits-1] &&
               (px < $signed({1'b0, frame_width_q})) &&
               (py < $signed({1'b0, frame_height_q}));
    fin = major_pos_q >= major_stop_q;
    err_sum = error_term_q + $signed({1'b0, error_gain_q});
    addr_calc = addr_t'(frame_width_q) * addr_t'(py[DimBits-1:0]) +
                addr_t'(px[DimBits-1:0]);
  end

  always_comb begin
    busy_d       = busy_q;
    steep_d      = steep_q;
    major_pos_d  = major_pos_q;
    major_stop_d = major_stop_q;
    minor_pos_d  = minor_pos_q;
    minor_dir_d  = minor_dir_q;
    error_term_d = error_term_q;
    error_gain_d = error_gain_q;
    error_drop_d = error_drop_q;
    line_color_d = line_color_q;
    if (s1_move && (s1_cmd_q == CmdLoad)) begin
      busy_d  = 1'b1;
      steep_d = ld_steep;
      if (maj1 < maj0) begin
        major_pos_d = maj1; major_stop_d = maj0; minor_pos_d = min1;
      end else begin
        major_pos_d = maj0; major_stop_d = maj1; minor_pos_d = min0;
      end
      minor_dir_d  = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
      error_term_d = -$signed({3'b000, maj_span});
      error_gain_d = {1'b0, min_span, 1'b0};
      error_drop_d = {1'b0, maj_span, 1'b0};
      line_color_d = s1_color_q;
    end else if (s1_step && busy_q) begin
      if (fin) begin
        busy_d = 1'b0;
      end else begin
        major_pos_d  = major_pos_q + coord_t'(1);
        error_term_d = err_sum;
        if (!err_sum[ErrBits-1]) begin
          minor_pos_d  = minor_dir_q ? minor_pos_q - coord_t'(1)
                                     : minor_pos_q + coord_t'(1);
          error_term_d = err_sum - $signed({1'b0, error_drop_q});
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q      <= steep_d;
    major_pos_q  <= major_pos_d;
    major_stop_q <= major_stop_d;
    minor_pos_q  <= minor_pos_d;
    minor_dir_q  <= minor_dir_d;
    error_term_q <= error_term_d;
    error_gain_q <= error_gain_d;
    error_drop_q <= error_drop_d;
    line_color_q <= line_color_d;
  end

  // result register
  logic out_valid_q, out_valid_d;

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i) begin
    if (s1_step) begin
      pixel_valid_o  <= busy_q;
      write_enable_o <= busy_q && in_frame;
      pixel_x_o      <= busy_q ? px : '0;
      pixel_y_o      <= busy_q ? py : '0;
      address_o      <= (busy_q && in_frame) ? addr_calc : '0;
      out_color_o    <= busy_q ? line_color_q : '0;
      last_o         <= busy_q && fin;
    end
  end

  // checks
  `LR_ASSERT(a_idle_pixel_zero,
    out_valid_o && !pixel_valid_o |-> !write_enable_o && !last_o && address_o == '0
      && pixel_x_o == '0 && pixel_y_o == '0,
    "step with no active line gave a nonzero pixel")
  `LR_ASSERT(a_clip_addr_zero,
    out_valid_o && !write_enable_o |-> address_o == '0,
    "clipped pixel carries an address")
  `LR_ASSERT(a_written_in_frame,
    out_valid_o && write_enable_o |-> !pixel_x_o[CoordBits-1] && !pixel_y_o[CoordBits-1],
    "written pixel has a negative coordinate")
  `LR_ASSERT(a_last_ends_line,
    s1_step && busy_q && fin |=> !busy_q && out_valid_o && last_o,
    "final pixel did not end the line")
  `LR_ASSERT_ALWAYS(a_reset_empty,
    !rst_ni |=> !out_valid_o && !s1_valid_q && !busy_q,
    "pipeline not empty in reset")

endmodule

### tb/line_rasterizer_checker.sv
// pixel predictor and result checker for the line rasterizer testbench
module line_rasterizer_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_ready_o,
  input  lr_pkg::cfg_idx_t cfg_index_i,
  input  lr_pkg::dim_t     cfg_data_i,
  input  logic             in_valid_i,
  input  logic             in_stall_o,
  input  logic             command_i,
  input  lr_pkg::coord_t   x_start_i,
  input  lr_pkg::coord_t   y_start_i,
  input  lr_pkg::coord_t   x_end_i,
  input  lr_pkg::coord_t   y_end_i,
  input  lr_pkg::color_t   pixel_color_i,
  input  logic             out_valid_o,
  input  logic             out_stall_i,
  input  logic             pixel_valid_o,
  input  logic             write_enable_o,
  input  lr_pkg::coord_t   pixel_x_o,
  input  lr_pkg::coord_t   pixel_y_o,
  input  lr_pkg::addr_t    address_o,
  input  lr_pkg::color_t   out_color_o,
  input  logic             last_o,
  output int               fail_count_o,
  output int               pixels_pending_o,
  output int               pixels_seen_o,
  output int               writes_seen_o,
  output int               line_ends_o
);
  import lr_pkg::*;

  typedef struct packed {
    logic   pixel_valid;
    logic   write_enable;
    coord_t px;
    coord_t py;
    addr_t  address;
    color_t color;
    logic   last;
  } pixel_t;

  pixel_t expected_pixels[$];

  dim_t   frame_width;
  dim_t   frame_height;
  logic   line_active;
  logic   steep_line;
  coord_t major_at;
  coord_t major_last;
  coord_t minor_at;
  logic   minor_down;
  err_t   err_acc;
  gain_t  err_rise;
  gain_t  err_fall;
  color_t line_color;

  task automatic report_mismatch(input string msg);
    $display("mismatch at pixel %0d: %s", pixels_seen_o, msg);
    fail_count_o++;
  endtask

  task automatic check_field(input string name, input longint got_v, input longint want_v);
    if (got_v != want_v) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got_v, want_v));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    int x0, y0, x1, y1, dx, dy, adx, ady;
    int maj0, maj1, min0, min1, maj_span, min_span;
    pixel_t got, want;
    coord_t px, py;
    logic in_frame;
    logic at_end;
    if (!rst_ni) begin
      expected_pixels.delete();
      frame_width = FrameDimReset;
      frame_height = FrameDimReset;
      line_active = 1'b0;
      steep_line = 1'b0;
      major_at = '0;
      major_last = '0;
      minor_at = '0;
      minor_down = 1'b0;
      err_acc = '0;
      err_rise = '0;
      err_fall = '0;
      line_color = '0;
      fail_count_o = 0;
      pixels_pending_o = 0;
      pixels_seen_o = 0;
      writes_seen_o = 0;
      line_ends_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CfgFrameWidth) begin
          frame_width = cfg_data_i;
        end else if (cfg_index_i == CfgFrameHeight) begin
          frame_height = cfg_data_i;
        end
      end

      if (out_valid_o && !out_stall_i) begin
        got = '{pixel_valid_o, write_enable_o, pixel_x_o, pixel_y_o, address_o,
                out_color_o, last_o};
        if (expected_pixels.size() == 0) begin
          report_mismatch("pixel result with nothing expected");
        end else begin
          want = expected_pixels.pop_front();
          check_field("pixel_valid", got.pixel_valid, want.pixel_valid);
          check_field("write_enable", got.write_enable, want.write_enable);
          check_field("pixel_x", got.px, want.px);
          check_field("pixel_y", got.py, want.py);
          check_field("address", got.address, want.address);
          check_field("out_color", got.color, want.color);
          check_field("last", got.last, want.last);
        end
        pixels_seen_o++;
        if (got.write_enable) writes_seen_o++;
        if (got.last) line_ends_o++;
      end

      if (in_valid_i && !in_stall_o) begin
        if (command_i == CmdLoad) begin
          x0 = x_start_i;
          y0 = y_start_i;
          x1 = x_end_i;
          y1 = y_end_i;
          dx = x1 - x0;
          dy = y1 - y0;
          adx = (dx < 0) ? -dx : dx;
          ady = (dy < 0) ? -dy : dy;
          steep_line = ady > adx;
          if (steep_line) begin
            maj0 = y0; maj1 = y1; min0 = x0; min1 = x1;
            maj_span = ady; min_span = adx;
          end else begin
            maj0 = x0; maj1 = x1; min0 = y0; min1 = y1;
            maj_span = adx; min_span = ady;
          end
          // walk always goes toward the larger major coordinate
          if (maj1 < maj0) begin
            major_at = coord_t'(maj1);
            major_last = coord_t'(maj0);
            minor_at = coord_t'(min1);
          end else begin
            major_at = coord_t'(maj0);
            major_last = coord_t'(maj1);
            minor_at = coord_t'(min0);
          end
          minor_down = (dx < 0 && dy > 0) || (dx > 0 && dy < 0);
          err_acc = err_t'(-maj_span);
          err_rise = gain_t'(2 * min_span);
          err_fall = gain_t'(2 * maj_span);
          line_color = pixel_color_i;
          line_active = 1'b1;
        end else begin
          want = '0;
          if (line_active) begin
            px = steep_line ? minor_at : major_at;
            py = steep_line ? major_at : minor_at;
            in_frame = px >= 0 && py >= 0 && int'(px) < int'(frame_width) &&
                       int'(py) < int'(frame_height);
            at_end = major_at >= major_last;
            want.pixel_valid = 1'b1;
            want.write_enable = in_frame;
            want.px = px;
            want.py = py;
            want.address = in_frame ?
                addr_t'(int'(frame_width) * int'(py) + int'(px)) : '0;
            want.color = line_color;
            want.last = at_end;
            if (at_end) begin
              line_active = 1'b0;
            end else begin
              major_at = coord_t'(int'(major_at) + 1);
              err_acc = err_t'(int'(err_acc) + int'(err_rise));
              // a tie at zero still moves the minor coordinate
              if (err_acc >= 0) begin
                minor_at = coord_t'(int'(minor_at) + (minor_down ? -1 : 1));
                err_acc = err_t'(int'(err_acc) - int'(err_fall));
              end
            end
          end
          expected_pixels.push_back(want);
        end
      end

      pixels_pending_o = expected_pixels.size();
    end
  end

endmodule

### tb/line_rasterizer_tb.sv
// testbench top for the line rasterizer: clock, reset, stimulus and verdict
module line_rasterizer_tb;
  import lr_pkg::*;

  localparam int HalfPeriod   = 10;
  localparam int ResetCycles  = 12;
  localparam int SettleCycles = 4;
  localparam int CycleLimit   = 400000;
  localparam int TotalItems   = 1950;
  localparam int NumPhases    = 8;
  localparam int IdlePct      = 36;
  localparam int CoordMax     = 2 ** (CoordBits - 1) - 1;
  localparam int CoordMin     = -(2 ** (CoordBits - 1));

  localparam cfg_idx_t CfgSpareLo = cfg_idx_t'(2);
  localparam cfg_idx_t CfgSpareHi = cfg_idx_t'(3);

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     cfg_valid_i;
  logic     cfg_ready_o;
  cfg_idx_t cfg_index_i;
  dim_t     cfg_data_i;
  logic     in_valid_i;
  logic     in_stall_o;
  logic     command_i;
  coord_t   x_start_i;
  coord_t   y_start_i;
  coord_t   x_end_i;
  coord_t   y_end_i;
  color_t   pixel_color_i;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  logic     pixel_valid_o;
  logic     write_enable_o;
  coord_t   pixel_x_o;
  coord_t   pixel_y_o;
  addr_t    address_o;
  color_t   out_color_o;
  logic     last_o;

  int fail_count_o;
  int pixels_pending_o;
  int pixels_seen_o;
  int writes_seen_o;
  int line_ends_o;

  int   cycle_count = 0;
  int   idle_pct = IdlePct;
  int   stall_pct = IdlePct;
  int   items_sent = 0;
  dim_t cur_width = FrameDimReset;
  dim_t cur_height = FrameDimReset;

  line_rasterizer dut (.*);

  line_rasterizer_checker checker_i (.*);

  always #(HalfPeriod) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic coord_t clamp_coord(input int v);
    return coord_t'((v > CoordMax) ? CoordMax : (v < CoordMin) ? CoordMin : v);
  endfunction

  // mostly near the frame so clipping edges get hit, some anywhere, some at the extremes
  function automatic coord_t pick_coord(input dim_t limit);
    case ($urandom_range(3))
      0, 1:    return clamp_coord(int'($urandom_range(0, limit + 16)) - 8);
      2:       return coord_t'($urandom);
      default: return $urandom_range(1) ? clamp_coord(CoordMax - int'($urandom_range(3)))
                                        : clamp_coord(CoordMin + int'($urandom_range(3)));
    endcase
  endfunction

  task automatic send_item(input logic cmd, input coord_t xs, input coord_t ys,
                           input coord_t xe, input coord_t ye, input color_t col);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    command_i     <= cmd;
    x_start_i     <= xs;
    y_start_i     <= ys;
    x_end_i       <= xe;
    y_end_i       <= ye;
    pixel_color_i <= col;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  // endpoint fields are don't-care on a step item, so fill them with noise
  task automatic step_line(input int n);
    repeat (n) begin
      send_item(CmdStep, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), $urandom);
    end
  endtask

  task automatic write_register(input cfg_idx_t idx, input dim_t value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (idx == CfgFrameWidth) cur_width = value;
    if (idx == CfgFrameHeight) cur_height = value;
  endtask

  // drain all pixels, then give trailing load items time to leave the pipeline
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pixels_pending_o != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    int target;
    int dx, dy, span, steps;
    coord_t xs, ys, xe, ye;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CfgFrameWidth;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    command_i     = CmdStep;
    x_start_i     = '0;
    y_start_i     = '0;
    x_end_i       = '0;
    y_end_i       = '0;
    pixel_color_i = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed lines on the reset frame size
    step_line(1);
    send_item(CmdLoad, coord_t'(0), coord_t'(0), coord_t'(0), coord_t'(0), 32'hFFFF_FFFF);
    step_line(2);
    send_item(CmdLoad, coord_t'(0), coord_t'(0), coord_t'(4), coord_t'(2), 32'h1234_5678);
    step_line(5);
    send_item(CmdLoad, coord_t'(1), coord_t'(-2), coord_t'(-1), coord_t'(2),
              32'h0000_0000);
    step_line(5);
    send_item(CmdLoad, coord_t'(CoordMin), coord_t'(CoordMax), coord_t'(CoordMax),
              coord_t'(CoordMin), 32'h8000_0001);
    step_line(2);
    send_item(CmdLoad, coord_t'(CoordMax), coord_t'(CoordMin), coord_t'(CoordMin),
              coord_t'(CoordMax), 32'h5555_AAAA);
    step_line(1);
    send_item(CmdLoad, coord_t'(798), coord_t'(799), coord_t'(800), coord_t'(799),
              32'hA5A5_5A5A);
    step_line(3);

    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      case (phase)
        0: begin
          write_register(CfgFrameWidth, dim_t'(4095));
          write_register(CfgFrameHeight, dim_t'(4095));
        end
        1: begin
          write_register(CfgFrameWidth, dim_t'(1));
          write_register(CfgFrameHeight, dim_t'(1));
        end
        2: begin
          write_register(CfgFrameWidth, dim_t'(0));
          write_register(CfgFrameHeight, dim_t'($urandom_range(1, 4095)));
          write_register(CfgSpareLo, dim_t'($urandom));
        end
        3: begin
          write_register(CfgFrameWidth, dim_t'(1));
          write_register(CfgFrameHeight, dim_t'(4095));
        end
        4: begin
          write_register(CfgFrameWidth, dim_t'(4095));
          write_register(CfgFrameHeight, dim_t'(1));
        end
        5: begin
          write_register(CfgFrameWidth, dim_t'($urandom_range(1, 4095)));
          write_register(CfgFrameHeight, dim_t'($urandom_range(1, 4095)));
          write_register(CfgSpareHi, dim_t'($urandom));
        end
        6: begin
          write_register(CfgFrameWidth, dim_t'($urandom_range(1, 64)));
          write_register(CfgFrameHeight, dim_t'(0));
        end
        default: begin
          write_register(CfgFrameWidth, FrameDimReset);
          write_register(CfgFrameHeight, FrameDimReset);
        end
      endcase
      cfg_valid_i <= 1'b0;
      // last phase runs with no gaps on either side
      idle_pct  = (phase == NumPhases - 1) ? 0 : IdlePct;
      stall_pct = idle_pct;

      target = (phase + 1) * TotalItems / NumPhases;
      while (items_sent < target) begin
        if ($urandom_range(9) == 0) begin
          send_item(1'($urandom_range(1)), coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), $urandom);
        end else begin
          xs = pick_coord(cur_width);
          ys = pick_coord(cur_height);
          case ($urandom_range(9))
            9: begin
              xe = coord_t'($urandom);
              ye = coord_t'($urandom);
            end
            7, 8: begin
              xe = clamp_coord(int'(xs) + int'($urandom_range(0, 600)) - 300);
              ye = clamp_coord(int'(ys) + int'($urandom_range(0, 600)) - 300);
            end
            default: begin
              xe = clamp_coord(int'(xs) + int'($urandom_range(0, 40)) - 20);
              ye = clamp_coord(int'(ys) + int'($urandom_range(0, 40)) - 20);
            end
          endcase
          dx = int'(xe) - int'(xs);
          dy = int'(ye) - int'(ys);
          if (dx < 0) dx = -dx;
          if (dy < 0) dy = -dy;
          span = ((dx > dy) ? dx : dy) + 1;
          // usually the whole line, sometimes one step past its end, sometimes cut short
          steps = span + (($urandom_range(3) == 0) ? 1 : 0);
          if ($urandom_range(4) == 0) steps = $urandom_range(0, span);
          if (steps > 120) steps = $urandom_range(5, 120);
          send_item(CmdLoad, xs, ys, xe, ye, $urandom);
          step_line(steps);
        end
      end
    end

    settle();
    $display("ran %0d items over %0d frame sizes, zero, one and 4095 among them",
             items_sent, NumPhases + 1);
    $display("compared %0d pixels: %0d inside the frame, %0d line ends",
             pixels_seen_o, writes_seen_o, line_ends_o);
    if (fail_count_o == 0 && pixels_pending_o == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d pixels still expected", fail_count_o, pixels_pending_o);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
